/* src/http_upgrade_header_extractor_assert.svh */
// Assertion macros shared by the RTL of the upgrade header extractor.
`ifndef HTTP_UPGRADE_HEADER_EXTRACTOR_ASSERT_SVH
`define HTTP_UPGRADE_HEADER_EXTRACTOR_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define HUHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HUHE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/huhe_pkg.sv */
package huhe_pkg;

  // Width of the internal request byte counter.
  localparam int CountBits = 16;
  localparam int LineBits  = 13;
  localparam int LenBits   = 16;

  localparam logic [LineBits-1:0] MaxLineReset = LineBits'(1024);

  // Result queue between the parser and the output side.
  localparam int FifoDepth = 4;
  localparam int PtrBits   = $clog2(FifoDepth);
  localparam int CntBits   = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Header keys, lowercase, left aligned in a field of the longest key.
  localparam int KeyMaxLen = 17;
  localparam logic [8*KeyMaxLen-1:0] KeyUpgrade = {"upgrade", 80'h0};
  localparam logic [8*KeyMaxLen-1:0] KeyWsKey   = "sec-websocket-key";
  localparam logic [8*KeyMaxLen-1:0] KeyHost    = {"host", 104'h0};
  localparam logic [4:0] KeyUpgradeLen = 5'd7;
  localparam logic [4:0] KeyWsKeyLen   = 5'd17;
  localparam logic [4:0] KeyHostLen    = 5'd4;
  localparam logic [4:0] KeyPosMax     = 5'd31;

  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_RESOURCE  = 4'd1,
    PH_REQREST   = 4'd2,
    PH_LINESTART = 4'd3,
    PH_KEY       = 4'd4,
    PH_SKIPSP    = 4'd5,
    PH_VALUE     = 4'd6,
    PH_IGNORE    = 4'd7,
    PH_FINAL     = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_METHOD     = 3'd0,
    KIND_RESOURCE   = 3'd1,
    KIND_UPGRADE    = 3'd2,
    KIND_WS_KEY     = 3'd3,
    KIND_HOST       = 3'd4,
    KIND_COMPLETE   = 3'd5,
    KIND_INCOMPLETE = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         value_byte;
    logic               field_end;
    logic               truncated;
    logic [LenBits-1:0] request_length;
  } out_item_t;

  // True when the key character at position pos equals ch.
  function automatic logic key_hit(input logic [8*KeyMaxLen-1:0] str,
                                   input logic [4:0] len,
                                   input logic [4:0] pos,
                                   input logic [7:0] ch);
    logic [7:0] c;
    c = 8'h00;
    if (pos < len) begin
      c = str[8*(KeyMaxLen-1-int'(pos)) +: 8];
    end
    return (pos < len) && (c == ch);
  endfunction

endpackage

/* src/huhe_front.sv */
module huhe_front import huhe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  in_item_t            item_i,
  input  logic [LineBits-1:0] max_line_i,
  output logic                res_valid_o,
  output out_item_t           res_o
);

  phase_e               phase_q, phase_d;
  logic [4:0]           key_pos_q, key_pos_d;
  logic [2:0]           cand_q, cand_d;
  logic [LineBits-1:0]  line_q, line_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 cut_q, cut_d;

  logic [7:0]           b;
  logic [7:0]           lc;
  logic                 is_lf, is_cr, is_sp, is_colon;
  logic                 in_line;
  logic                 done;
  logic [CountBits-1:0] cnt_inc;
  logic [32:0]          cnt_ext;
  kind_e                field_kind;

  assign b        = item_i.data_byte;
  assign lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  assign is_lf    = (b == ChLf);
  assign is_cr    = (b == ChCr);
  assign is_sp    = (b == ChSpace);
  assign is_colon = (b == ChColon);
  assign in_line  = (line_q < max_line_i);
  assign cnt_inc  = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_ext  = 33'(cnt_inc);
  assign done     = is_lf && (phase_q == PH_LINESTART || phase_q == PH_FINAL);
  assign field_kind = cand_q[0] ? KIND_UPGRADE : (cand_q[1] ? KIND_WS_KEY : KIND_HOST);

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    key_pos_d = key_pos_q;
    cand_d    = cand_q;
    line_d    = line_q;
    cut_d     = cut_q;
    cnt_d     = cnt_inc;
    if (is_lf) begin
      phase_d   = PH_LINESTART;
      key_pos_d = '0;
      cand_d    = 3'b111;
      line_d    = '0;
      cut_d     = 1'b0;
    end else if (!in_line) begin
      cut_d = 1'b1;
      if (line_q != '1) begin
        line_d = line_q + 1'b1;
      end
    end else begin
      line_d = line_q + 1'b1;
      case (phase_q)
        PH_METHOD: begin
          if (is_sp) phase_d = PH_RESOURCE;
        end
        PH_RESOURCE: begin
          if (is_sp) phase_d = PH_REQREST;
        end
        PH_LINESTART, PH_KEY: begin
          if (phase_q == PH_LINESTART && is_cr) begin
            phase_d = PH_FINAL;
          end else if (is_colon) begin
            cand_d = 3'b000;
            if (cand_q[0] && key_pos_q == KeyUpgradeLen) cand_d = 3'b001;
            if (cand_q[1] && key_pos_q == KeyWsKeyLen)   cand_d = 3'b010;
            if (cand_q[2] && key_pos_q == KeyHostLen)    cand_d = 3'b100;
            phase_d = (cand_d != 3'b000) ? PH_SKIPSP : PH_IGNORE;
          end else if (is_cr) begin
            phase_d = PH_IGNORE;
          end else begin
            cand_d[0] = cand_q[0] && key_hit(KeyUpgrade, KeyUpgradeLen, key_pos_q, lc);
            cand_d[1] = cand_q[1] && key_hit(KeyWsKey, KeyWsKeyLen, key_pos_q, lc);
            cand_d[2] = cand_q[2] && key_hit(KeyHost, KeyHostLen, key_pos_q, lc);
            if (key_pos_q != KeyPosMax) key_pos_d = key_pos_q + 5'd1;
            phase_d = PH_KEY;
          end
        end
        PH_SKIPSP: begin
          if (is_cr) phase_d = PH_IGNORE;
          else if (!is_sp) phase_d = PH_VALUE;
        end
        PH_VALUE: begin
          if (is_cr) phase_d = PH_IGNORE;
        end
        default: begin
        end
      endcase
    end
    if (done || item_i.buffer_end) begin
      phase_d   = PH_METHOD;
      key_pos_d = '0;
      cand_d    = 3'b111;
      line_d    = '0;
      cnt_d     = '0;
      cut_d     = 1'b0;
    end
  end

  // Result of the byte.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.truncated = cut_q;
    if (is_lf) begin
      case (phase_q)
        PH_METHOD: begin
          res_valid_o = 1'b1;
          res_o.kind = KIND_METHOD;
          res_o.field_end = 1'b1;
        end
        PH_RESOURCE: begin
          res_valid_o = 1'b1;
          res_o.kind = KIND_RESOURCE;
          res_o.field_end = 1'b1;
        end
        PH_SKIPSP, PH_VALUE: begin
          res_valid_o = 1'b1;
          res_o.kind = field_kind;
          res_o.field_end = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (in_line) begin
      case (phase_q)
        PH_METHOD, PH_RESOURCE: begin
          res_valid_o = 1'b1;
          res_o.kind = (phase_q == PH_METHOD) ? KIND_METHOD : KIND_RESOURCE;
          if (is_sp) res_o.field_end = 1'b1;
          else res_o.value_byte = b;
        end
        PH_SKIPSP, PH_VALUE: begin
          if (!(phase_q == PH_SKIPSP && is_sp)) begin
            res_valid_o = 1'b1;
            res_o.kind = field_kind;
            if (is_cr) res_o.field_end = 1'b1;
            else res_o.value_byte = b;
          end
        end
        default: begin
        end
      endcase
    end
    if (done) begin
      res_valid_o = 1'b1;
      res_o = '0;
      res_o.kind = KIND_COMPLETE;
      res_o.request_length = (cnt_ext > 33'd65535) ? '1 : cnt_ext[LenBits-1:0];
    end else if (item_i.buffer_end) begin
      res_valid_o = 1'b1;
      res_o = '0;
      res_o.kind = KIND_INCOMPLETE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_METHOD;
      key_pos_q <= '0;
      cand_q    <= 3'b111;
      line_q    <= '0;
      cnt_q     <= '0;
      cut_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      key_pos_q <= key_pos_d;
      cand_q    <= cand_d;
      line_q    <= line_d;
      cnt_q     <= cnt_d;
      cut_q     <= cut_d;
    end
  end

endmodule

/* src/huhe_fifo.sv */
`include "http_upgrade_header_extractor_assert.svh"

module huhe_fifo import huhe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output out_item_t data_o
);

  out_item_t            mem_q [FifoDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrBits'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrBits'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  `HUHE_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || cnt_q <= CntBits'(FifoDepth), "queue count over depth")
  `HUHE_ASSERT(a_cnt_up, (do_push && !do_pop) |=> cnt_q == CntBits'($past(cnt_q) + 1'b1), "queue count did not grow")
  `HUHE_ASSERT(a_cnt_dn, (do_pop && !do_push) |=> cnt_q == CntBits'($past(cnt_q) - 1'b1), "queue count did not shrink")
  `HUHE_ASSERT(a_no_lost_push, push_i |-> !full_o, "result pushed into a full queue")

endmodule

/* src/http_upgrade_header_extractor.sv */
// HTTP upgrade header extractor. Takes one request byte per transaction and
// streams out the method and resource of the request line and the values of
// the upgrade, sec-websocket-key and host headers, each field closed by an
// end marker, then a completion result with the saturated request length at
// the blank line, or an incomplete result when the buffer ends early. A
// byte is classified in the cycle it is accepted, and its result, if any,
// enters a four-entry result queue that drives the output channel, so the
// block sustains one byte per clock and keeps taking bytes while results
// wait, stalling input only when the queue is full. The maximum line length
// register may be written only while idle.
`include "http_upgrade_header_extractor_assert.svh"

module http_upgrade_header_extractor import huhe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [LineBits-1:0] cfg_data_i
);

  logic [LineBits-1:0] max_line_q;
  logic                accept;
  logic                res_valid;
  out_item_t           res;
  logic                full;

  // A byte is taken whenever the queue has room for its possible result.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MaxLineReset;
    end else if (cfg_we_i) begin
      max_line_q <= cfg_data_i;
    end
  end

  // Front: per-byte parser and field classifier.
  huhe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .max_line_i  (max_line_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Back: result queue feeding the output channel.
  huhe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && res_valid),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .pop_i   (out_ready_i),
    .data_o  (out_data_o)
  );

  `HUHE_ASSERT(a_marker_zero, (out_valid_o && out_data_o.field_end) |-> out_data_o.value_byte == 8'h00, "end marker carries a byte")
  `HUHE_ASSERT(a_len_only_done, (out_valid_o && out_data_o.kind != KIND_COMPLETE) |-> out_data_o.request_length == '0, "length on a non-completion result")
  `HUHE_ASSERT(a_cfg_reg, cfg_we_i |=> max_line_q == $past(cfg_data_i), "line length register not written")

endmodule

/* verif/http_upgrade_header_extractor_checker.sv */
module http_upgrade_header_extractor_checker import huhe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [LineBits-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LineBits-1:0]  LineLimitReset = LineBits'(1024);
  localparam logic [LineBits-1:0]  LineCountMax   = '1;
  localparam logic [CountBits-1:0] ByteCountMax   = '1;

  // Shadow copy of the parser state and of the line length register.
  phase_e               hdr_phase;
  logic [4:0]           key_pos;
  logic [2:0]           key_live;
  logic [LineBits-1:0]  line_pos;
  logic [CountBits-1:0] req_count;
  logic                 line_cut;
  logic [LineBits-1:0]  max_line;

  out_item_t expected_fields[$];
  out_item_t want;
  out_item_t pred;
  int        mismatches = 0;

  // Bit i of key_live stands for key i here.
  function automatic string key_name(input int idx);
    case (idx)
      0: return "upgrade";
      1: return "sec-websocket-key";
      default: return "host";
    endcase
  endfunction

  function automatic void clear_parse();
    hdr_phase = PH_METHOD;
    key_pos   = '0;
    key_live  = 3'b111;
    line_pos  = '0;
    req_count = '0;
    line_cut  = 1'b0;
  endfunction

  function automatic out_item_t field_item(input kind_e kind, input logic [7:0] val,
                                           input logic fin);
    out_item_t r;
    r.kind           = kind;
    r.value_byte     = val;
    r.field_end      = fin;
    r.truncated      = line_cut;
    r.request_length = '0;
    return r;
  endfunction

  function automatic kind_e header_kind();
    if (key_live[0]) return KIND_UPGRADE;
    if (key_live[1]) return KIND_WS_KEY;
    return KIND_HOST;
  endfunction

  function automatic void match_key_byte(input logic [7:0] b);
    logic [7:0] lc;
    logic [2:0] keep;
    string      name;
    int         i;
    if (b == ChColon) begin
      // The key is known only if the whole name was seen; a later key wins.
      keep = '0;
      for (i = 0; i < 3; i++) begin
        if (key_live[i] && int'(key_pos) == key_name(i).len()) keep = 3'b001 << i;
      end
      key_live = keep;
      if (keep != '0) hdr_phase = PH_SKIPSP;
      else hdr_phase = PH_IGNORE;
    end else if (b == ChCr) begin
      hdr_phase = PH_IGNORE;
    end else begin
      lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      for (i = 0; i < 3; i++) begin
        name = key_name(i);
        if (!(int'(key_pos) < name.len() && 8'(name[int'(key_pos)]) == lc)) key_live[i] = 1'b0;
      end
      if (key_pos != 5'd31) key_pos++;
      hdr_phase = PH_KEY;
    end
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input in_item_t item, output out_item_t res);
    logic [7:0] b;
    bit         have;
    bit         done;
    b    = item.data_byte;
    have = 1'b0;
    done = 1'b0;
    res  = '0;
    if (req_count != ByteCountMax) req_count++;
    if (b == ChLf) begin
      case (hdr_phase)
        PH_METHOD: begin
          res  = field_item(KIND_METHOD, 8'h00, 1'b1);
          have = 1'b1;
        end
        PH_RESOURCE: begin
          res  = field_item(KIND_RESOURCE, 8'h00, 1'b1);
          have = 1'b1;
        end
        PH_SKIPSP, PH_VALUE: begin
          res  = field_item(header_kind(), 8'h00, 1'b1);
          have = 1'b1;
        end
        PH_LINESTART, PH_FINAL: done = 1'b1;
        default: ;
      endcase
      hdr_phase = PH_LINESTART;
      key_pos   = '0;
      key_live  = 3'b111;
      line_pos  = '0;
      line_cut  = 1'b0;
    end else if (line_pos >= max_line) begin
      line_cut = 1'b1;
      if (line_pos != LineCountMax) line_pos++;
    end else begin
      line_pos++;
      case (hdr_phase)
        PH_METHOD: begin
          have = 1'b1;
          if (b == ChSpace) begin
            res       = field_item(KIND_METHOD, 8'h00, 1'b1);
            hdr_phase = PH_RESOURCE;
          end else begin
            res = field_item(KIND_METHOD, b, 1'b0);
          end
        end
        PH_RESOURCE: begin
          have = 1'b1;
          if (b == ChSpace) begin
            res       = field_item(KIND_RESOURCE, 8'h00, 1'b1);
            hdr_phase = PH_REQREST;
          end else begin
            res = field_item(KIND_RESOURCE, b, 1'b0);
          end
        end
        PH_LINESTART: begin
          if (b == ChCr) hdr_phase = PH_FINAL;
          else match_key_byte(b);
        end
        PH_KEY: match_key_byte(b);
        PH_SKIPSP, PH_VALUE: begin
          if (b == ChCr) begin
            res       = field_item(header_kind(), 8'h00, 1'b1);
            have      = 1'b1;
            hdr_phase = PH_IGNORE;
          end else if (!(b == ChSpace && hdr_phase == PH_SKIPSP)) begin
            res       = field_item(header_kind(), b, 1'b0);
            have      = 1'b1;
            hdr_phase = PH_VALUE;
          end
        end
        default: ;
      endcase
    end

    if (done) begin
      res.kind           = KIND_COMPLETE;
      res.value_byte     = 8'h00;
      res.field_end      = 1'b0;
      res.truncated      = 1'b0;
      res.request_length = (32'(req_count) > 32'hFFFF) ? 16'hFFFF : 16'(req_count);
      have               = 1'b1;
      clear_parse();
    end else if (item.buffer_end) begin
      res      = '0;
      res.kind = KIND_INCOMPLETE;
      have     = 1'b1;
      clear_parse();
    end
    return have;
  endfunction

  function automatic string item_text(input out_item_t r);
    return $sformatf("kind %0d byte %02h end %b cut %b length %0d",
                     r.kind, r.value_byte, r.field_end, r.truncated, r.request_length);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      max_line = LineLimitReset;
      expected_fields.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: result with nothing expected: got %s", $time, item_text(out_data_i));
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          if (out_data_i !== want) begin
            $display("%0t: mismatch: expected %s, got %s", $time, item_text(want),
                     item_text(out_data_i));
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(in_data_i, pred)) expected_fields.push_back(pred);
      end
      if (cfg_we_i) max_line = cfg_data_i;
    end
    pending_o <= expected_fields.size();
    errors_o  <= mismatches;
  end

endmodule

/* verif/http_upgrade_header_extractor_test.sv */
// The top level makes the stimulus and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module http_upgrade_header_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import huhe_pkg::*;

  localparam int ResetCycles = 11;
  // The receiver holds off this long once, so the result queue fills up and
  // the block has to stall its input.
  localparam int LongHold    = 200;
  // Cycles without any transaction before the run is given up. The longest
  // correct quiet stretch is the long hold plus a long sender gap.
  localparam int StallLimit  = 4000;
  // Cycles left after the last expected result, so that a byte that causes
  // no result has surely left the block before the register is written.
  localparam int SettleCycles = 4;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_we    = 1'b0;
  logic [LineBits-1:0] cfg_data  = '0;

  int       mismatches;
  int       pending;
  int       hold_requests = 0;
  bit       no_idle       = 1'b0;
  int       sent_bytes    = 0;
  in_item_t byte_plan[$];

  // Period of 8 ns.
  always #4 clk = ~clk;

  http_upgrade_header_extractor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  http_upgrade_header_extractor_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  // Most gaps are zero or short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // A byte that may appear inside a method, resource or header value: never
  // a space, CR or LF, mostly printable, now and then any other byte.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(33, 126));
    end while (c == ChSpace || c == ChCr || c == ChLf);
    return c;
  endfunction

  // Any byte except LF, used as junk after a CR.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 254));
    if (c >= ChLf) c++;
    return c;
  endfunction

  // Key matching ignores case, so letters get a random case.
  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  // Keys that come close to a known key without being one.
  function automatic string near_key();
    case ($urandom_range(0, 4))
      0: return "hos";
      1: return "hostt";
      2: return "upgrad";
      3: return "sec-websocket-ke";
      default: return "x-upgrade";
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] value, input logic last);
    in_item_t it;
    it.data_byte  = value;
    it.buffer_end = last;
    byte_plan.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(mix_case(8'(s[i])), 1'b0);
  endfunction

  // A line ends in CR LF, in a bare LF, or in CR, some junk and then LF.
  function automatic void push_eol(input logic last);
    int n;
    case ($urandom_range(0, 7))
      0, 1: ;
      2: begin
        push_byte(ChCr, 1'b0);
        n = $urandom_range(1, 3);
        repeat (n) push_byte(junk_char(), 1'b0);
      end
      default: push_byte(ChCr, 1'b0);
    endcase
    push_byte(ChLf, last);
  endfunction

  // A request with random content. Most are well formed, some end the
  // request line early, and some are cut off by an early buffer end.
  function automatic void build_request();
    int    start;
    int    n;
    int    cut_at;
    string key;
    start = byte_plan.size();
    n = $urandom_range(0, 5);
    repeat (n) push_byte(field_char(), 1'b0);
    if ($urandom_range(0, 11) == 0) begin
      push_byte(ChLf, 1'b0);
    end else begin
      push_byte(ChSpace, 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) push_byte(field_char(), 1'b0);
      if ($urandom_range(0, 11) == 0) begin
        push_byte(ChLf, 1'b0);
      end else begin
        push_byte(ChSpace, 1'b0);
        push_text("HTTP/1.1");
        push_eol(1'b0);
      end
    end

    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: key = "upgrade";
        3, 4: key = "sec-websocket-key";
        5, 6: key = "host";
        7: key = near_key();
        8: key = "sec-websocket-key-with-a-very-long-tail";
        default: key = "";
      endcase
      push_text(key);
      if ($urandom_range(0, 9) == 0) begin
        // A line with no colon; a CR may land in the key.
        push_eol(1'b0);
      end else begin
        push_byte(ChColon, 1'b0);
        repeat ($urandom_range(0, 3)) push_byte(ChSpace, 1'b0);
        repeat ($urandom_range(0, 8)) push_byte(field_char(), 1'b0);
        push_eol(1'b0);
      end
    end

    // The blank line; the buffer may end on its LF too.
    push_eol($urandom_range(0, 3) == 0);

    if ($urandom_range(0, 7) == 0) begin
      cut_at = $urandom_range(start, byte_plan.size() - 1);
      byte_plan[cut_at].buffer_end = 1'b1;
      while (byte_plan.size() > cut_at + 1) void'(byte_plan.pop_back());
    end
  endfunction

  // Random bytes of the whole range, closed by a buffer end so that the
  // next request starts from the reset state.
  function automatic void push_noise();
    int n;
    n = $urandom_range(4, 24);
    repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // Offers every planned byte as one transaction each, with random gaps.
  task automatic send_plan();
    int gap;
    while (byte_plan.size() > 0) begin
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= byte_plan.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent_bytes++;
    end
    in_valid <= 1'b0;
  endtask

  // Waits until every expected result has been taken, then lets the block
  // settle. The count from the checker is registered, hence the first wait.
  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic set_max_line(input int unsigned value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= LineBits'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // The receiver decides once per cycle. A hold request from the stimulus
  // turns into one long stretch with ready low.
  initial begin : receiver
    int hold_left;
    int idle_left;
    int holds_done;
    hold_left  = 0;
    idle_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LongHold;
      end else if (idle_left > 0) begin
        idle_left--;
      end else if (!no_idle) begin
        idle_left = pick_gap();
      end
      out_ready <= (hold_left == 0) && (idle_left == 0);
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("http_upgrade_header_extractor test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned limit_pick;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset line limit. The request line carries the
    // smallest and largest byte as method and resource, then a host header
    // in mixed case whose value ends in a bare LF, then the blank line. A
    // lone byte with the buffer end flag gives an incomplete result, and an
    // LF inside the method ends that field only, before an LF completes.
    push_byte(8'h00, 1'b0);
    push_byte(ChSpace, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(ChSpace, 1'b0);
    push_byte(ChCr, 1'b0);
    push_byte(ChLf, 1'b0);
    push_text("HOST: v");
    push_byte(ChLf, 1'b0);
    push_byte(ChCr, 1'b0);
    push_byte(ChLf, 1'b0);
    push_byte("z", 1'b1);
    push_byte(ChLf, 1'b0);
    push_byte(ChLf, 1'b0);
    send_plan();

    // Shortest line limit: all but the first two bytes of a line are cut.
    set_max_line(2);
    repeat (3) build_request();
    send_plan();

    // Widest line limit, while the receiver holds off for a long stretch.
    set_max_line(4096);
    repeat (4) build_request();
    hold_requests++;
    send_plan();

    // Random phases, each under a fresh limit. Every phase starts only after
    // the block has delivered every expected result.
    while (sent_bytes < 380) begin
      case ($urandom_range(0, 6))
        0: limit_pick = 2;
        1: limit_pick = 4096;
        2: limit_pick = 1024;
        3: limit_pick = $urandom_range(41, 4096);
        default: limit_pick = $urandom_range(3, 40);
      endcase
      set_max_line(limit_pick);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) build_request();
      if ($urandom_range(0, 2) == 0) push_noise();
      send_plan();
    end

    drain_results();
    if (mismatches == 0) begin
      $display("http_upgrade_header_extractor test passed");
    end else begin
      $display("http_upgrade_header_extractor test failed");
    end
    $finish;
  end

endmodule
